// File: hdl/per_service_circuit_breaker_core_macros.svh
// ----------------------------------------------------------------------------
// per_service_circuit_breaker_core_macros
// Assertion macros for the circuit breaker core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PER_SERVICE_CIRCUIT_BREAKER_CORE_MACROS_SVH
`define PER_SERVICE_CIRCUIT_BREAKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define PSCB_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define PSCB_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define PSCB_ASSERT(name, prop)
`define PSCB_ASSERT_NEVER(name, cond)

`endif

`endif

// File: hdl/pscb_pkg.sv
// ----------------------------------------------------------------------------
// pscb_pkg
// Fixed widths, request codes and register indexes of the breaker core.
// ----------------------------------------------------------------------------
package pscb_pkg;

    localparam int SVC_W    = 6;
    localparam int SERVICES = 2 ** SVC_W;

    localparam int MODE_W   = 3;
    localparam int CNT_W    = 8;
    localparam int THR_W    = 8;
    localparam int CD_W     = 31;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUCCESS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAILURE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OPEN_Q  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 1'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;
    localparam logic [CD_W-1:0]  COOLDOWN_RESET  = 31'd5000;

endpackage

// File: hdl/per_service_circuit_breaker_core.sv
// ----------------------------------------------------------------------------
// per_service_circuit_breaker_core
// Table of 64 circuit breakers with a tick-driven time base.
//
// Requests enter on the in channel (valid/ready) as a mode and a service
// index: tick, allow query, success report, failure report or open query.
// Every accepted word gives exactly one result word (allowed, is_open) on the
// out channel (valid/ready), in order.
// An accepted word is registered in the request stage, and its result then
// in the result register. Throughput: one word per cycle while the receiver
// does not stall, set by the single read-modify-write of one table entry
// (registered read, bypass from the write of the word just ahead).
// Thresholds and cooldown come from a plain write port (index 0 threshold,
// index 1 cooldown); the user must write them while the core is idle (not enforced).
// Reset: all breakers read closed with zero count, time is zero; per-entry
// valid bits clear at once, so the core takes words right out of reset.
// When the receiver stalls, the result register holds, the request stage
// holds, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
`include "per_service_circuit_breaker_core_macros.svh"

module per_service_circuit_breaker_core
    import pscb_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [SVC_W-1:0]     service,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 allowed,
    output logic                 is_open
);

    // Width of the reopen-time sum before it wraps to the time base.
    localparam int SUM_W = (TIME_BITS > CD_W) ? TIME_BITS : CD_W;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic                 open;
        logic [TIME_BITS-1:0] reopen;
    } entry_t;

    // Configuration
    logic [THR_W-1:0]     thr_reg;
    logic [CD_W-1:0]      cd_reg;

    // Time base
    logic [TIME_BITS-1:0] time_now_reg;
    logic [TIME_BITS-1:0] time_now_next;

    // Entry table and its valid bits
    entry_t               mem [SERVICES];
    logic [SERVICES-1:0]  entry_valid_reg;

    // Request stage
    logic                 s1_valid_reg;
    logic [MODE_W-1:0]    s1_mode_reg;
    logic [SVC_W-1:0]     s1_svc_reg;
    entry_t               rd_mem_reg;
    logic                 rd_valid_reg;
    entry_t               fwd_entry_reg;
    logic                 fwd_hit_reg;

    // Result stage
    logic                 out_valid_reg;
    logic                 out_allowed_reg;
    logic                 out_open_reg;

    logic                 in_fire;
    logic                 s1_fire;
    entry_t               cur_entry;
    entry_t               new_entry;
    logic                 wr_req;
    logic                 wr_en;
    logic [CNT_W-1:0]     cnt_inc;
    logic [TIME_BITS-1:0] elapsed_diff;
    logic [SUM_W-1:0]     reopen_sum;
    logic                 res_allowed;
    logic                 res_open;

    // Advance the request stage when the result register is free or drains.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    // Entry as seen by the word in the request stage: the write of the word
    // ahead wins, then the table, and a never-written entry reads as zero.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_entry = fwd_entry_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_entry = rd_mem_reg;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    assign cnt_inc      = (cur_entry.count == CNT_MAX) ? cur_entry.count
                                                       : cur_entry.count + CNT_W'(1);
    // Wrap-safe compare: elapsed once now minus reopen has a clear top bit.
    assign elapsed_diff = time_now_reg - cur_entry.reopen;
    assign reopen_sum   = SUM_W'(time_now_reg) + SUM_W'(cd_reg);

    always_comb
    begin
        new_entry   = cur_entry;
        wr_req      = 1'b0;
        res_allowed = 1'b0;
        res_open    = 1'b0;
        case (s1_mode_reg)
            MODE_TICK:
            begin
                res_open = 1'b0;
            end
            MODE_ALLOW:
            begin
                res_allowed = !cur_entry.open || !elapsed_diff[TIME_BITS-1];
                res_open    = cur_entry.open;
            end
            MODE_SUCCESS:
            begin
                new_entry.count = '0;
                new_entry.open  = 1'b0;
                wr_req          = 1'b1;
                res_open        = 1'b0;
            end
            MODE_FAILURE:
            begin
                new_entry.count = cnt_inc;
                if (cnt_inc >= thr_reg)
                begin
                    new_entry.open   = 1'b1;
                    new_entry.reopen = reopen_sum[TIME_BITS-1:0];
                end
                wr_req   = 1'b1;
                res_open = new_entry.open;
            end
            MODE_OPEN_Q:
            begin
                res_open = cur_entry.open;
            end
            default:
            begin
                res_open = 1'b0;
            end
        endcase
    end

    assign wr_en = s1_fire && wr_req;

    assign time_now_next = (s1_fire && (s1_mode_reg == MODE_TICK))
                           ? time_now_reg + TIME_BITS'(1) : time_now_reg;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THRESHOLD_RESET;
            cd_reg          <= COOLDOWN_RESET;
            time_now_reg    <= '0;
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    REG_COOLDOWN:  cd_reg  <= cfg_data[CD_W-1:0];
                    default:       thr_reg <= thr_reg;
                endcase
            end
            time_now_reg <= time_now_next;
            if (wr_en)
            begin
                entry_valid_reg[s1_svc_reg] <= 1'b1;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table write-back
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_svc_reg] <= new_entry;
        end
    end

    // Capture the request and its registered table read; hold while stalled.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg   <= mode;
            s1_svc_reg    <= service;
            rd_mem_reg    <= mem[service];
            rd_valid_reg  <= entry_valid_reg[service];
            fwd_entry_reg <= new_entry;
            fwd_hit_reg   <= wr_en && (s1_svc_reg == service);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_allowed_reg <= res_allowed;
            out_open_reg    <= res_open;
        end
    end

    assign out_valid = out_valid_reg;
    assign allowed   = out_allowed_reg;
    assign is_open   = out_open_reg;

    // A full, stalled pipe must refuse new words.
    `PSCB_ASSERT(a_full_stall_blocks, s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
    // Only success and failure reports touch the table.
    `PSCB_ASSERT_NEVER(a_write_mode, wr_en && (s1_mode_reg != MODE_SUCCESS) && (s1_mode_reg != MODE_FAILURE))
    // A tick yields an all-zero result word.
    `PSCB_ASSERT(a_tick_result, s1_fire && (s1_mode_reg == MODE_TICK) |=> out_valid && !allowed && !is_open)

endmodule
